/* sv/sldf_pkg.sv */
`default_nettype none
package sldf_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int MAX_PAYLOAD  = 20;
    localparam int MIN_SCAN     = 7;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int IW = $clog2(MAX_PAYLOAD + 1);
    localparam int LW = 8;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SYNC_FIRST  = 2'd0;
    localparam t_cfg_idx CFG_SYNC_SECOND = 2'd1;
    localparam t_cfg_idx CFG_END_MARKER  = 2'd2;
    localparam t_cfg_idx CFG_MAX_LENGTH  = 2'd3;

    typedef logic [2:0] t_rd;
    localparam t_rd RD_NONE     = 3'd0;
    localparam t_rd RD_B0       = 3'd1;
    localparam t_rd RD_B1       = 3'd2;
    localparam t_rd RD_B2       = 3'd3;
    localparam t_rd RD_B3       = 3'd4;
    localparam t_rd RD_END      = 3'd5;
    localparam t_rd RD_PL_FIRST = 3'd6;
    localparam t_rd RD_PL_NEXT  = 3'd7;

    typedef logic [2:0] t_drop;
    localparam t_drop DROP_NONE  = 3'd0;
    localparam t_drop DROP_1     = 3'd1;
    localparam t_drop DROP_2     = 3'd2;
    localparam t_drop DROP_4     = 3'd3;
    localparam t_drop DROP_FRAME = 3'd4;

    typedef logic [1:0] t_emit;
    localparam t_emit EMIT_NONE  = 2'd0;
    localparam t_emit EMIT_EMPTY = 2'd1;
    localparam t_emit EMIT_PAY   = 2'd2;

    typedef struct packed {
        logic  store;
        t_rd   rd;
        t_drop drop;
        t_emit emit;
        logic  len_ld;
        logic  pl_init;
    } t_cmd;

    typedef struct packed {
        logic count_ge_min;
        logic b0_bad;
        logic b1_bad;
        logic hdr_bad;
        logic frame_ready;
        logic end_bad;
        logic len_zero;
        logic pl_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* sv/sldf_ctrl.sv */
`default_nettype none
module sldf_ctrl
    import sldf_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_B0    = 4'd2;
    localparam logic [3:0] S_B1    = 4'd3;
    localparam logic [3:0] S_B2    = 4'd4;
    localparam logic [3:0] S_B3    = 4'd5;
    localparam logic [3:0] S_END   = 4'd6;
    localparam logic [3:0] S_PL    = 4'd7;
    localparam logic [3:0] S_EMPTY = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.rd      = RD_NONE;
        o_cmd.drop    = DROP_NONE;
        o_cmd.emit    = EMIT_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.count_ge_min) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.rd = RD_B0;
                    n_state  = S_B0;
                end
            end
            S_B0: begin
                if (i_sts.b0_bad) begin
                    o_cmd.drop = DROP_1;
                    n_state    = S_CHK;
                end else begin
                    o_cmd.rd = RD_B1;
                    n_state  = S_B1;
                end
            end
            S_B1: begin
                if (i_sts.b1_bad) begin
                    o_cmd.drop = DROP_2;
                    n_state    = S_CHK;
                end else begin
                    o_cmd.rd = RD_B2;
                    n_state  = S_B2;
                end
            end
            S_B2: begin
                o_cmd.len_ld = 1'b1;
                o_cmd.rd     = RD_B3;
                n_state      = S_B3;
            end
            S_B3: begin
                if (i_sts.hdr_bad) begin
                    o_cmd.drop = DROP_4;
                    n_state    = S_CHK;
                end else if (i_sts.frame_ready) begin
                    o_cmd.rd = RD_END;
                    n_state  = S_END;
                end else begin
                    // frame not complete yet, wait for more bytes
                    n_state = S_IDLE;
                end
            end
            S_END: begin
                if (i_sts.end_bad) begin
                    o_cmd.drop = DROP_1;
                    n_state    = S_CHK;
                end else if (i_sts.len_zero) begin
                    n_state = S_EMPTY;
                end else begin
                    o_cmd.pl_init = 1'b1;
                    o_cmd.rd      = RD_PL_FIRST;
                    n_state       = S_PL;
                end
            end
            S_PL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EMIT_PAY;
                    if (i_sts.pl_last) begin
                        o_cmd.drop = DROP_FRAME;
                        n_state    = S_CHK;
                    end else begin
                        o_cmd.rd = RD_PL_NEXT;
                    end
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = EMIT_EMPTY;
                    o_cmd.drop = DROP_FRAME;
                    n_state    = S_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* sv/sldf_dpath.sv */
`default_nettype none
module sldf_dpath
    import sldf_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cfg_wr_en,
    input  wire  [1:0]     i_cfg_index,
    input  wire  [7:0]     i_cfg_data,
    input  wire  [7:0]     i_rx_byte,
    input  wire            i_block_start,
    input  wire            i_out_stall,
    input  t_cmd           i_cmd,
    output t_sts           o_sts,
    output logic           o_out_valid,
    output logic [7:0]     o_payload_byte,
    output logic           o_frame_last,
    output logic           o_check_ok,
    output logic           o_frame_empty
);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (s >= (CW + 1)'(WINDOW_DEPTH)) begin
            s = s - (CW + 1)'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [7:0]    r_mem [WINDOW_DEPTH];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;

    logic [7:0]    r_sync_first;
    logic [7:0]    r_sync_second;
    logic [7:0]    r_end_marker;
    logic [4:0]    r_max_length;

    logic [LW-1:0] r_len;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_cs;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_ok;
    logic          r_out_empty;

    logic [AW-1:0] eff_head;
    logic [CW-1:0] eff_count;
    logic          full;
    logic [AW-1:0] waddr;
    logic [CW-1:0] rd_off;
    logic [CW-1:0] drop_n;
    logic [LW-1:0] limit;
    logic [LW:0]   hdr_sum;
    logic          out_free;

    assign limit = (LW'(r_max_length) > LW'(MAX_PAYLOAD)) ? LW'(MAX_PAYLOAD)
                                                           : LW'(r_max_length);
    assign hdr_sum  = {1'b0, r_len} + {1'b0, r_rdata};
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.count_ge_min = (r_count >= CW'(MIN_SCAN));
    assign o_sts.b0_bad       = (r_rdata != r_sync_first);
    assign o_sts.b1_bad       = (r_rdata != r_sync_second);
    assign o_sts.hdr_bad      = (hdr_sum != (LW + 1)'(255)) || (r_len > limit);
    assign o_sts.frame_ready  = ((LW + 1)'(r_count) > ({1'b0, r_len} + (LW + 1)'(4)));
    assign o_sts.end_bad      = (r_rdata != r_end_marker);
    assign o_sts.len_zero     = (r_len == '0);
    assign o_sts.pl_last      = (r_idx == IW'(r_len - LW'(1)));
    assign o_sts.out_free     = out_free;

    // block start restarts the window before the byte is stored
    assign eff_head  = i_block_start ? '0 : r_head;
    assign eff_count = i_block_start ? '0 : r_count;
    assign full      = (eff_count == CW'(WINDOW_DEPTH));
    assign waddr     = full ? eff_head : wrap_add(eff_head, eff_count);

    always_comb begin
        case (i_cmd.rd)
            RD_B0:       rd_off = CW'(0);
            RD_B1:       rd_off = CW'(1);
            RD_B2:       rd_off = CW'(2);
            RD_B3:       rd_off = CW'(3);
            RD_END:      rd_off = CW'(r_len) + CW'(4);
            RD_PL_FIRST: rd_off = CW'(4);
            RD_PL_NEXT:  rd_off = CW'(r_idx) + CW'(5);
            default:     rd_off = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.drop)
            DROP_1:     drop_n = CW'(1);
            DROP_2:     drop_n = CW'(2);
            DROP_4:     drop_n = CW'(4);
            DROP_FRAME: drop_n = CW'(r_len) + CW'(5);
            default:    drop_n = '0;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.store) begin
            n_head  = full ? wrap_add(eff_head, CW'(1)) : eff_head;
            n_count = full ? eff_count : eff_count + CW'(1);
        end else if (i_cmd.drop != DROP_NONE) begin
            n_head  = wrap_add(r_head, drop_n);
            n_count = r_count - drop_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[waddr] <= i_rx_byte;
        end
        if (i_cmd.rd != RD_NONE) begin
            r_rdata <= r_mem[wrap_add(r_head, rd_off)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= '0;
            r_sync_first  <= 8'h55;
            r_sync_second <= 8'haa;
            r_end_marker  <= 8'h03;
            r_max_length  <= 5'd20;
            r_out_valid   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                    CFG_END_MARKER:  r_end_marker  <= i_cfg_data;
                    CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.emit != EMIT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.len_ld) begin
            r_len <= r_rdata;
        end
        if (i_cmd.pl_init) begin
            r_idx <= '0;
            r_cs  <= '0;
        end else if (i_cmd.emit == EMIT_PAY) begin
            r_idx <= r_idx + IW'(1);
            r_cs  <= r_cs ^ r_rdata;
        end
        case (i_cmd.emit)
            EMIT_PAY: begin
                r_out_byte  <= r_rdata;
                r_out_last  <= o_sts.pl_last;
                r_out_ok    <= o_sts.pl_last && (r_cs == r_rdata);
                r_out_empty <= 1'b0;
            end
            EMIT_EMPTY: begin
                r_out_byte  <= 8'h00;
                r_out_last  <= 1'b1;
                r_out_ok    <= 1'b0;
                r_out_empty <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_frame_last   = r_out_last;
    assign o_check_ok     = r_out_ok;
    assign o_frame_empty  = r_out_empty;

endmodule
`default_nettype wire

/* sv/sync_length_frame_deframer.sv */
// a byte is taken while idle, then the scan reads one window byte per cycle while the
// output is not stalled; the next byte is taken once the scan returns to idle, which it does
// with fewer than 7 held or when a partial frame is held, and each dropped head adds a rescan
// one item at a time: no new byte is taken until the scan is done; an empty frame gives one
// item, and a payload goes out one item per cycle while the output is not stalled
// reset: synchronous active-low; empties the window and loads the default registers
`default_nettype none
module sync_length_frame_deframer
    import sldf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire  [1:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [7:0] i_rx_byte,
    input  wire        i_block_start,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_last,
    output logic       o_check_ok,
    output logic       o_frame_empty
);

    t_cmd cmd;
    t_sts sts;

    sldf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sldf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .i_block_start  (i_block_start),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_frame_last   (o_frame_last),
        .o_check_ok     (o_check_ok),
        .o_frame_empty  (o_frame_empty)
    );

endmodule
`default_nettype wire
